// ===== rtl/core/fwk_pkg.sv =====
// Shared widths, codes and types for the Fenwick add and rank-select core.
package fwk_pkg;

   localparam int TREE_SIZE_DEF = 1024;
   localparam int POS_W         = 11;
   localparam int DELTA_W       = 9;
   localparam int RANK_W        = 16;
   localparam int NODE_W        = 16;

   typedef enum logic {
      REQ_ADD    = 1'b0,
      REQ_SELECT = 1'b1
   } req_kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [NODE_W-1:0] value;
      logic              borrow;
      logic              zero;
   } alu_res_type;

endpackage

// ===== rtl/core/fwk_channels.sv =====
// Request and response channel interfaces of the Fenwick core.
interface fwk_req_if;
   import fwk_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [POS_W-1:0]          position;
   logic signed [DELTA_W-1:0] delta;
   logic [RANK_W-1:0]         rank;

   modport source (output valid, output req_type, output position, output delta,
                   output rank, input ready);
   modport sink   (input valid, input req_type, input position, input delta,
                   input rank, output ready);
endinterface

interface fwk_rsp_if;
   import fwk_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] found_position;
   logic             beyond_total;

   modport source (output valid, output found_position, output beyond_total,
                   input ready);
   modport sink   (input valid, input found_position, input beyond_total,
                   output ready);
endinterface

// ===== rtl/core/fwk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fwk_ram #(
   parameter int WIDTH = fwk_pkg::NODE_W,
   parameter int DEPTH = fwk_pkg::TREE_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/core/fwk_alu.sv =====
// Shared 16-bit add/subtract unit with borrow and zero flags.
module fwk_alu (
   input  fwk_pkg::alu_op_type            op,
   input  logic [fwk_pkg::NODE_W-1:0]     a,
   input  logic [fwk_pkg::NODE_W-1:0]     b,
   output fwk_pkg::alu_res_type           res
);
   import fwk_pkg::*;

   logic [NODE_W:0] wide;

   always_comb begin
      unique case (op)
         ALU_ADD: wide = {1'b0, a} + {1'b0, b};
         ALU_SUB: wide = {1'b0, a} - {1'b0, b};
         default: wide = '0;
      endcase
      res.value  = wide[NODE_W-1:0];
      res.borrow = (op == ALU_SUB) && wide[NODE_W];
      res.zero   = (wide[NODE_W-1:0] == '0);
   end

endmodule

// ===== rtl/core/fenwick_add_and_rank_select_core.sv =====
// Fenwick tree core: add at a position, select the smallest position reaching a rank.
// Add: updates each node on the upward path; each node write also issues the next node's read.
// Select: sums the popcount(TREE_SIZE) nodes of the root path into a total, then descends over
//   floor(log2(TREE_SIZE))+1 levels; all node reads share the single RAM read port.
// One item at a time; a finished select holds off the next request until the response
//   register is free.
// Reset clears the tree in a pass over every node during which no request is taken.
module fenwick_add_and_rank_select_core #(
   parameter int TREE_SIZE = fwk_pkg::TREE_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   fwk_req_if.sink   req_bus,
   fwk_rsp_if.source rsp_bus
);
   import fwk_pkg::*;

   localparam int PW       = $clog2(TREE_SIZE + 1) + 1;
   localparam int AW       = $clog2(TREE_SIZE);
   localparam int TOP_STEP = 1 << ($clog2(TREE_SIZE + 1) - 1);
   localparam logic [PW-1:0] LAST_POS = PW'(TREE_SIZE);

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_ADD_RD  = 9'b000000100,
      S_ADD_WR  = 9'b000001000,
      S_TOT_RD  = 9'b000010000,
      S_TOT_ACC = 9'b000100000,
      S_TOT_CHK = 9'b001000000,
      S_DSC_RD  = 9'b010000000,
      S_DSC_CMP = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      done_ff, done_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [PW-1:0]             step_ff, step_in;
   logic [PW-1:0]             at_ff, at_in;
   logic [NODE_W-1:0]         acc_ff, acc_in;
   logic [RANK_W-1:0]         want_ff, want_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic                      beyond_ff, beyond_in;
   logic [AW-1:0]             clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic                      rsp_beyond_ff, rsp_beyond_in;

   logic [PW-1:0]     pos_low;
   logic [PW-1:0]     pos_up;
   logic [PW-1:0]     pos_dn;
   logic [PW-1:0]     dsc_next;
   logic [PW-1:0]     at_inc;
   logic [31:0]       at_wide;
   logic [PW-1:0]     rd_pos;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [NODE_W-1:0] wr_data;
   logic [NODE_W-1:0] ram_rdata;
   alu_op_type        alu_op;
   logic [NODE_W-1:0] alu_a;
   logic [NODE_W-1:0] alu_b;
   alu_res_type       alu_res;
   logic              req_take;
   logic              pos_ok;
   logic              rsp_free;
   logic              over;

   fwk_ram #(
      .WIDTH (NODE_W),
      .DEPTH (TREE_SIZE)
   ) u_nodes (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (AW'(rd_pos - PW'(1))),
      .rd_data_ff (ram_rdata)
   );

   fwk_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   assign req_bus.ready          = (state_ff == S_IDLE) && !done_ff;
   assign req_take               = req_bus.valid && req_bus.ready;
   assign pos_ok                 = (req_bus.position != '0) &&
                                   (32'(req_bus.position) <= 32'(TREE_SIZE));
   assign rsp_free               = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.found_position = rsp_pos_ff;
   assign rsp_bus.beyond_total   = rsp_beyond_ff;

   assign pos_low  = pos_ff & (~pos_ff + PW'(1));
   assign pos_up   = pos_ff + pos_low;
   assign pos_dn   = pos_ff - pos_low;
   assign dsc_next = at_ff + step_ff;
   assign at_inc   = at_ff + PW'(1);
   assign at_wide  = 32'(at_inc);
   assign over     = beyond_ff || (at_inc > LAST_POS);

   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      at_in         = at_ff;
      acc_in        = acc_ff;
      want_in       = want_ff;
      delta_in      = delta_ff;
      beyond_in     = beyond_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_beyond_in = rsp_beyond_ff;
      rd_pos        = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(pos_ff - PW'(1));
      wr_data       = alu_res.value;
      alu_op        = ALU_ADD;
      alu_a         = ram_rdata;
      alu_b         = NODE_W'(delta_ff);

      // publish a finished select once the output slot frees
      if (done_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_beyond_in = over;
         rsp_pos_in    = over ? '0 : at_wide[POS_W-1:0];
         done_in       = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(TREE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_bus.req_type == REQ_SELECT) begin
                  want_in  = req_bus.rank;
                  acc_in   = '0;
                  pos_in   = LAST_POS;
                  state_in = S_TOT_RD;
               end else if (pos_ok) begin
                  pos_in   = PW'(req_bus.position);
                  delta_in = req_bus.delta;
                  state_in = S_ADD_RD;
               end
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            wr_en  = 1'b1;
            pos_in = pos_up;
            rd_pos = pos_up;
            if (pos_up > LAST_POS) begin
               state_in = S_IDLE;
            end
         end
         S_TOT_RD: begin
            state_in = S_TOT_ACC;
         end
         S_TOT_ACC: begin
            alu_b  = acc_ff;
            acc_in = alu_res.value;
            pos_in = pos_dn;
            rd_pos = pos_dn;
            if (pos_dn == '0) begin
               state_in = S_TOT_CHK;
            end
         end
         S_TOT_CHK: begin
            alu_op    = ALU_SUB;
            alu_a     = acc_ff;
            alu_b     = want_ff;
            beyond_in = alu_res.borrow;
            at_in     = '0;
            step_in   = PW'(TOP_STEP);
            if (alu_res.borrow) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DSC_RD;
            end
         end
         S_DSC_RD: begin
            rd_pos = dsc_next;
            if (dsc_next <= LAST_POS) begin
               state_in = S_DSC_CMP;
            end else begin
               step_in = step_ff >> 1;
               if (step_ff == PW'(1)) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_DSC_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = want_ff;
            alu_b  = ram_rdata;
            // advance when the node count is below the remaining rank
            if (!alu_res.borrow && !alu_res.zero) begin
               want_in = alu_res.value;
               at_in   = dsc_next;
            end
            step_in = step_ff >> 1;
            if (step_ff == PW'(1)) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DSC_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      at_ff         <= at_in;
      acc_ff        <= acc_in;
      want_ff       <= want_in;
      delta_ff      <= delta_in;
      beyond_ff     <= beyond_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_beyond_ff <= rsp_beyond_in;
   end

   a_select_starts_total: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_bus.req_type == REQ_SELECT) |=> state_ff == S_TOT_RD)
      else $error("select did not start the total walk");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done_ff))
      else $error("response raised without a finished select");

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DSC_CMP |-> $past(state_ff == S_DSC_RD))
      else $error("descent compare without a preceding node read");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !req_take)
      else $error("request taken while a select result is unpublished");

   a_beyond_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beyond_ff |-> rsp_pos_ff == '0)
      else $error("beyond-total response carries a nonzero position");

endmodule

// ===== tb/sv/tb_fenwick_add_and_rank_select_core.sv =====
// Self-checking testbench for the Fenwick add and rank-select core.
module tb_fenwick_add_and_rank_select_core;
   import fwk_pkg::*;

   localparam int TREE_SIZE    = TREE_SIZE_DEF;
   localparam int ITEM_COUNT   = 1150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct {
      req_kind_type              kind;
      logic [POS_W-1:0]          position;
      logic signed [DELTA_W-1:0] delta;
      logic [RANK_W-1:0]         rank;
   } fenwick_req_type;

   typedef struct {
      logic [POS_W-1:0] found_position;
      logic             beyond_total;
   } rank_answer_type;

   logic clock = 1'b0;
   logic reset;

   fwk_req_if req_bus ();
   fwk_rsp_if rsp_bus ();

   fenwick_add_and_rank_select_core #(
      .TREE_SIZE (TREE_SIZE)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [NODE_W-1:0] tree_counts [1:TREE_SIZE];
   fenwick_req_type   request_queue [$];
   rank_answer_type   pending_answers [$];
   fenwick_req_type   on_bus;
   logic [NODE_W-1:0] planned_total;
   int                send_gap;
   int                hold_left;
   bit                send_gaps_on = 1'b1;
   bit                hold_gaps_on = 1'b1;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_wait(ref bit gaps_on);
      if ($urandom_range(0, 29) == 0) begin
         gaps_on = !gaps_on;
      end
      return gaps_on ? $urandom_range(0, 5) : 0;
   endfunction

   function automatic void tree_count_add(fenwick_req_type item);
      int                idx;
      logic [NODE_W-1:0] amount;
      idx    = int'(item.position);
      amount = NODE_W'(item.delta);
      while (idx >= 1 && idx <= TREE_SIZE) begin
         tree_counts[idx] = tree_counts[idx] + amount;
         idx += idx & -idx;
      end
   endfunction

   function automatic rank_answer_type rank_lookup(logic [RANK_W-1:0] wanted);
      logic [NODE_W-1:0] total;
      logic [RANK_W-1:0] remain;
      int                idx;
      int                at;
      int                stride;
      rank_answer_type   answer;
      total = '0;
      idx   = TREE_SIZE;
      while (idx > 0) begin
         total = total + tree_counts[idx];
         idx  -= idx & -idx;
      end
      answer.found_position = '0;
      answer.beyond_total   = 1'b1;
      if (wanted > total) begin
         return answer;
      end
      stride = 1;
      while (stride * 2 <= TREE_SIZE) begin
         stride *= 2;
      end
      remain = wanted;
      at     = 0;
      for (; stride > 0; stride /= 2) begin
         if (at + stride <= TREE_SIZE && tree_counts[at + stride] < remain) begin
            remain = remain - tree_counts[at + stride];
            at     = at + stride;
         end
      end
      at += 1;
      if (at <= TREE_SIZE) begin
         answer.found_position = POS_W'(at);
         answer.beyond_total   = 1'b0;
      end
      return answer;
   endfunction

   function automatic void apply_request(fenwick_req_type item);
      if (item.kind == REQ_ADD) begin
         tree_count_add(item);
      end else begin
         pending_answers.push_back(rank_lookup(item.rank));
      end
   endfunction

   function automatic void queue_add(int pos, int amount);
      fenwick_req_type item;
      item.kind     = REQ_ADD;
      item.position = POS_W'(pos);
      item.delta    = DELTA_W'(amount);
      item.rank     = RANK_W'($urandom);
      if (pos >= 1 && pos <= TREE_SIZE) begin
         planned_total = planned_total + NODE_W'(amount);
      end
      request_queue.push_back(item);
   endfunction

   function automatic void queue_select(int wanted);
      fenwick_req_type item;
      item.kind     = REQ_SELECT;
      item.position = POS_W'($urandom);
      item.delta    = DELTA_W'($urandom);
      item.rank     = RANK_W'(wanted);
      request_queue.push_back(item);
   endfunction

   function automatic void fill_random(int count);
      int pick;
      int pos;
      int amount;
      int top;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 45) begin
            pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(1, TREE_SIZE);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               amount = $urandom_range(1, 40);
            end else if (pick < 92) begin
               amount = -$urandom_range(1, 40);
            end else begin
               amount = $urandom_range(0, 511) - 256;
            end
            queue_add(pos, amount);
         end else begin
            top  = (planned_total == 0) ? 1 : int'(planned_total);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               queue_select($urandom_range(1, top));
            end else if (pick < 85) begin
               queue_select((planned_total + $urandom_range(1, 50)) & 16'hFFFF);
            end else if (pick < 95) begin
               queue_select($urandom_range(0, 65535));
            end else begin
               queue_select(0);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.req_type <= REQ_ADD;
         req_bus.position <= '0;
         req_bus.delta    <= '0;
         req_bus.rank     <= '0;
         send_gap = 0;
         for (int i = 1; i <= TREE_SIZE; i++) begin
            tree_counts[i] = '0;
         end
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            apply_request(on_bus);
            send_gap = draw_wait(send_gaps_on);
         end else if (send_gap > 0) begin
            send_gap--;
         end
         if (send_gap == 0 && request_queue.size() > 0) begin
            on_bus = request_queue.pop_front();
            req_bus.req_type <= on_bus.kind;
            req_bus.position <= on_bus.position;
            req_bus.delta    <= on_bus.delta;
            req_bus.rank     <= on_bus.rank;
            req_bus.valid    <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rank_answer_type wanted;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected beat: found_position %0d beyond_total %0b",
                      rsp_bus.found_position, rsp_bus.beyond_total);
               mismatch_count++;
            end else begin
               wanted = pending_answers.pop_front();
               if (rsp_bus.found_position !== wanted.found_position) begin
                  $error("found_position: expected %0d, got %0d",
                         wanted.found_position, rsp_bus.found_position);
                  mismatch_count++;
               end
               if (rsp_bus.beyond_total !== wanted.beyond_total) begin
                  $error("beyond_total: expected %0b, got %0b",
                         wanted.beyond_total, rsp_bus.beyond_total);
                  mismatch_count++;
               end
            end
            hold_left = draw_wait(hold_gaps_on);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_bus.ready <= (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** fenwick_add_and_rank_select_core: FAILED **");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      planned_total = '0;

      // empty tree, zero rank, ignored positions
      queue_select(1);
      queue_select(0);
      queue_add(0, 5);
      queue_add(TREE_SIZE + 1, 7);
      queue_add(2047, -256);
      queue_add(1, 255);
      queue_add(TREE_SIZE, 3);
      queue_add(TREE_SIZE / 2, 1);
      queue_add(TREE_SIZE / 2 + 1, 2);
      queue_select(1);
      queue_select(255);
      queue_select(256);
      queue_select(257);
      queue_select(258);
      queue_select(261);
      queue_select(262);
      queue_select(65535);
      // drive counts inconsistent, probe, then repair
      queue_add(700, -256);
      queue_select(3);
      queue_select(5);
      queue_add(700, 255);
      queue_add(700, 1);
      queue_select(0);
      queue_select(259);
      fill_random(ITEM_COUNT - request_queue.size());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() > 0 || req_bus.valid || pending_answers.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("** fenwick_add_and_rank_select_core: PASSED **");
      end else begin
         $display("** fenwick_add_and_rank_select_core: FAILED **");
      end
      $finish;
   end

endmodule
